// File: hdl/csvp_pkg.sv
// ----------------------------------------------------------------------------
// csvp_pkg: shared types and constants for the CSV byte stream parser
// Byte classes, queue entry, parser states and result codes.
// ----------------------------------------------------------------------------
package csvp_pkg;

  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_COMMA,
    CLS_NEWLINE,
    CLS_QUOTE,
    CLS_EOI
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] ch;
  } qitem_t;

  typedef enum logic [2:0] {
    ST_FIELD_START,
    ST_UNQUOTED,
    ST_QUOTED,
    ST_QUOTE_SEEN,
    ST_DONE
  } pstate_t;

  typedef enum logic [1:0] {
    K_CONTENT = 2'd0,
    K_FIELD   = 2'd1,
    K_RECORD  = 2'd2,
    K_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MISMATCH  = 3'd1,
    ERR_ESCAPE    = 3'd2,
    ERR_NO_QUOTE  = 3'd3,
    ERR_MISPLACED = 3'd4
  } err_t;

  typedef struct packed {
    logic       valid;
  } qctl_t;

endpackage

// File: hdl/csvp_front.sv
// ----------------------------------------------------------------------------
// csvp_front: input stage
// Accepts items while the queue has room and classifies each byte.
// ----------------------------------------------------------------------------
module csvp_front (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] char_in
  input  logic [0:0]        s_tuser,   // [0] mode
  input  logic              q_full,
  output logic              push,
  output csvp_pkg::qitem_t  push_item
);

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    push_item.ch = s_tdata;
    if (s_tuser[0]) begin
      push_item.cls = csvp_pkg::CLS_EOI;
    end else begin
      unique case (s_tdata)
        csvp_pkg::CH_COMMA:   push_item.cls = csvp_pkg::CLS_COMMA;
        csvp_pkg::CH_NEWLINE: push_item.cls = csvp_pkg::CLS_NEWLINE;
        csvp_pkg::CH_QUOTE:   push_item.cls = csvp_pkg::CLS_QUOTE;
        default:              push_item.cls = csvp_pkg::CLS_OTHER;
      endcase
    end
  end

endmodule

// File: hdl/csvp_queue.sv
// ----------------------------------------------------------------------------
// csvp_queue: classified item queue
// Short first-in first-out buffer between the input and parser stages.
// ----------------------------------------------------------------------------
module csvp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  csvp_pkg::qitem_t  push_item,
  input  logic              pop,
  output logic              full,
  output csvp_pkg::qctl_t   ctl,
  output csvp_pkg::qitem_t  head
);

  csvp_pkg::qitem_t                    entries [csvp_pkg::QDepth];
  logic [csvp_pkg::QPtrW-1:0]          wr_ptr;
  logic [csvp_pkg::QPtrW-1:0]          rd_ptr;
  logic [csvp_pkg::QPtrW:0]            count;
  logic                                do_push;
  logic                                do_pop;

  assign full      = (count == (csvp_pkg::QPtrW+1)'(csvp_pkg::QDepth));
  assign ctl.valid = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && ctl.valid;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/csvp_back.sv
// ----------------------------------------------------------------------------
// csvp_back: parser stage
// Runs the field and record state machine and registers at most one result per item.
// ----------------------------------------------------------------------------
module csvp_back #(
  parameter int MAX_FIELDS = 255
) (
  input  logic              clk,
  input  logic              rst,
  input  csvp_pkg::qctl_t   q_ctl,
  input  csvp_pkg::qitem_t  q_head,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // [7:0] char_out, [15:8] field_index,
                                       // [23:16] record_fields, [26:24] error_code,
                                       // [27] done_res
  output logic [1:0]        m_tuser    // [1:0] kind
);

  localparam int         FieldCap  = (MAX_FIELDS < 255) ? MAX_FIELDS : 255;
  localparam logic [7:0] FieldLast = 8'(FieldCap - 1);

  csvp_pkg::pstate_t state, state_next;
  logic [7:0]        field_counter, field_counter_next;
  logic [7:0]        first_record_fields, first_record_fields_next;
  logic              first_record_seen, first_record_seen_next;
  logic              at_record_start, at_record_start_next;

  logic              res_valid;
  csvp_pkg::kind_t   res_kind;
  logic [7:0]        res_char;
  logic [7:0]        res_recf;
  csvp_pkg::err_t    res_err;
  logic              res_done;

  logic              do_field, do_record, rec_final, do_fail, do_content, to_done;
  csvp_pkg::err_t    fail_code;
  logic [7:0]        rec_n;

  assign pop   = q_ctl.valid && (!m_tvalid || m_tready);
  assign rec_n = field_counter + 8'd1;

  always_comb begin
    state_next               = state;
    field_counter_next       = field_counter;
    first_record_fields_next = first_record_fields;
    first_record_seen_next   = first_record_seen;
    at_record_start_next     = at_record_start;
    do_field   = 1'b0;
    do_record  = 1'b0;
    rec_final  = 1'b0;
    do_fail    = 1'b0;
    do_content = 1'b0;
    to_done    = 1'b0;
    fail_code  = csvp_pkg::ERR_NONE;
    res_valid  = 1'b0;
    res_kind   = csvp_pkg::K_CONTENT;
    res_char   = 8'd0;
    res_recf   = 8'd0;
    res_err    = csvp_pkg::ERR_NONE;
    res_done   = 1'b0;

    unique case (state)
      csvp_pkg::ST_FIELD_START: begin
        case (q_head.cls)
          csvp_pkg::CLS_EOI: begin
            if (at_record_start) to_done = 1'b1;
            else begin
              do_record = 1'b1;
              rec_final = 1'b1;
            end
          end
          csvp_pkg::CLS_COMMA:   do_field = 1'b1;
          csvp_pkg::CLS_NEWLINE: do_record = 1'b1;
          csvp_pkg::CLS_QUOTE: begin
            at_record_start_next = 1'b0;
            state_next           = csvp_pkg::ST_QUOTED;
          end
          default: begin
            at_record_start_next = 1'b0;
            state_next           = csvp_pkg::ST_UNQUOTED;
            do_content           = 1'b1;
          end
        endcase
      end
      csvp_pkg::ST_UNQUOTED: begin
        case (q_head.cls)
          csvp_pkg::CLS_EOI: begin
            do_record = 1'b1;
            rec_final = 1'b1;
          end
          csvp_pkg::CLS_COMMA:   do_field = 1'b1;
          csvp_pkg::CLS_NEWLINE: do_record = 1'b1;
          csvp_pkg::CLS_QUOTE: begin
            do_fail   = 1'b1;
            fail_code = csvp_pkg::ERR_MISPLACED;
          end
          default: do_content = 1'b1;
        endcase
      end
      csvp_pkg::ST_QUOTED: begin
        case (q_head.cls)
          csvp_pkg::CLS_EOI: begin
            do_fail   = 1'b1;
            fail_code = csvp_pkg::ERR_NO_QUOTE;
          end
          csvp_pkg::CLS_QUOTE: state_next = csvp_pkg::ST_QUOTE_SEEN;
          default: do_content = 1'b1;
        endcase
      end
      csvp_pkg::ST_QUOTE_SEEN: begin
        case (q_head.cls)
          csvp_pkg::CLS_EOI: begin
            do_record = 1'b1;
            rec_final = 1'b1;
          end
          csvp_pkg::CLS_COMMA:   do_field = 1'b1;
          csvp_pkg::CLS_NEWLINE: do_record = 1'b1;
          csvp_pkg::CLS_QUOTE: begin
            state_next = csvp_pkg::ST_QUOTED;
            do_content = 1'b1;
          end
          default: begin
            do_fail   = 1'b1;
            fail_code = csvp_pkg::ERR_ESCAPE;
          end
        endcase
      end
      default: ;
    endcase

    if (to_done) state_next = csvp_pkg::ST_DONE;

    if (do_content) begin
      res_valid = 1'b1;
      res_kind  = csvp_pkg::K_CONTENT;
      res_char  = q_head.ch;
    end

    if (do_fail) begin
      res_valid  = 1'b1;
      res_kind   = csvp_pkg::K_ERROR;
      res_err    = fail_code;
      res_done   = 1'b1;
      state_next = csvp_pkg::ST_DONE;
    end

    if (do_field) begin
      res_valid            = 1'b1;
      res_kind             = csvp_pkg::K_FIELD;
      at_record_start_next = 1'b0;
      state_next           = csvp_pkg::ST_FIELD_START;
      if (field_counter < FieldLast) field_counter_next = field_counter + 8'd1;
    end

    if (do_record) begin
      res_valid = 1'b1;
      res_recf  = rec_n;
      if (first_record_seen && (rec_n != first_record_fields)) begin
        res_kind   = csvp_pkg::K_ERROR;
        res_err    = csvp_pkg::ERR_MISMATCH;
        res_done   = 1'b1;
        state_next = csvp_pkg::ST_DONE;
      end else begin
        if (!first_record_seen) begin
          first_record_seen_next   = 1'b1;
          first_record_fields_next = rec_n;
        end
        res_kind             = csvp_pkg::K_RECORD;
        res_done             = rec_final;
        field_counter_next   = 8'd0;
        at_record_start_next = 1'b1;
        state_next           = rec_final ? csvp_pkg::ST_DONE : csvp_pkg::ST_FIELD_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= csvp_pkg::ST_FIELD_START;
      field_counter       <= 8'd0;
      first_record_fields <= 8'd0;
      first_record_seen   <= 1'b0;
      at_record_start     <= 1'b1;
    end else if (pop) begin
      state               <= state_next;
      field_counter       <= field_counter_next;
      first_record_fields <= first_record_fields_next;
      first_record_seen   <= first_record_seen_next;
      at_record_start     <= at_record_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      m_tdata <= {4'd0, res_done, res_err, res_recf, field_counter, res_char};
      m_tuser <= res_kind;
    end
  end

endmodule

// File: hdl/csv_byte_stream_parser_core.sv
// Each accepted item is stored in the queue; its result, if any, is registered at the output.
// Throughput: one item per cycle while the output is not stalled.
// A four-entry queue decouples input acceptance from output stalls.
// Reset (rst, synchronous, active high) empties the queue and output register
// and returns the parser to the start of a record.
// ----------------------------------------------------------------------------
// csv_byte_stream_parser_core: CSV byte stream parser
// Splits CSV text into content bytes, field ends and record ends with errors.
// ----------------------------------------------------------------------------
module csv_byte_stream_parser_core #(
  parameter int MAX_FIELDS = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic [0:0]  s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] char_out, [15:8] field_index,
                                 // [23:16] record_fields, [26:24] error_code,
                                 // [27] done_res
  output logic [1:0]  m_tuser    // [1:0] kind
);

  logic              push;
  logic              pop;
  logic              q_full;
  csvp_pkg::qitem_t  push_item;
  csvp_pkg::qitem_t  q_head;
  csvp_pkg::qctl_t   q_ctl;

  csvp_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  csvp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .ctl       (q_ctl),
    .head      (q_head)
  );

  csvp_back #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_ctl    (q_ctl),
    .q_head   (q_head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: CSV byte stream parser testbench
// Streams one CSV document through the parser, with random gaps on both
// sides. A scoreboard tracks the parse state, works out each result and
// checks the output stream against it. The document opens with a fixed pair
// of records and continues with random ones. It closes with a randomly chosen
// ending: a clean end of input, a field count mismatch, a bad escape, a
// missing quote or a misplaced quote. Some trailing items follow, which the
// parser must ignore.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MaxFields  = 255;
  localparam int FieldCap   = (MaxFields < 255) ? MaxFields : 255;
  localparam int NumFields  = 4;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic       eoi;
    logic [7:0] ch;
  } text_item_t;

  typedef struct {
    csvp_pkg::kind_t kind;
    logic [7:0]      ch;
    logic [7:0]      idx;
    logic [7:0]      recf;
    csvp_pkg::err_t  err;
    logic            done;
  } parse_res_t;

  class csv_scoreboard;
    csvp_pkg::pstate_t state;
    logic [7:0]        field_cnt;
    logic [7:0]        first_cnt;
    bit                first_seen;
    bit                at_start;
    parse_res_t        expected_q[$];
    int                errors;

    function new();
      state      = csvp_pkg::ST_FIELD_START;
      field_cnt  = '0;
      first_cnt  = '0;
      first_seen = 1'b0;
      at_start   = 1'b1;
      errors     = 0;
    endfunction

    function void emit(csvp_pkg::kind_t kind, logic [7:0] ch, logic [7:0] recf,
                       csvp_pkg::err_t err, logic done);
      parse_res_t r;
      r.kind = kind;
      r.ch   = ch;
      r.idx  = field_cnt;
      r.recf = recf;
      r.err  = err;
      r.done = done;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void close_field();
      emit(csvp_pkg::K_FIELD, 8'h00, 8'h00, csvp_pkg::ERR_NONE, 1'b0);
      if (int'(field_cnt) + 1 < FieldCap) field_cnt++;
      state    = csvp_pkg::ST_FIELD_START;
      at_start = 1'b0;
    endfunction

    function void close_record(bit last);
      logic [7:0] n;
      n = field_cnt + 8'd1;
      if (!first_seen) begin
        first_seen = 1'b1;
        first_cnt  = n;
      end else if (n != first_cnt) begin
        emit(csvp_pkg::K_ERROR, 8'h00, n, csvp_pkg::ERR_MISMATCH, 1'b1);
        state = csvp_pkg::ST_DONE;
        return;
      end
      emit(csvp_pkg::K_RECORD, 8'h00, n, csvp_pkg::ERR_NONE, last);
      field_cnt = '0;
      at_start  = 1'b1;
      state     = last ? csvp_pkg::ST_DONE : csvp_pkg::ST_FIELD_START;
    endfunction

    function void abort(csvp_pkg::err_t err);
      emit(csvp_pkg::K_ERROR, 8'h00, 8'h00, err, 1'b1);
      state = csvp_pkg::ST_DONE;
    endfunction

    function void note_input(logic eoi, logic [7:0] ch);
      case (state)
        csvp_pkg::ST_FIELD_START: begin
          if (eoi) begin
            if (at_start) state = csvp_pkg::ST_DONE;
            else close_record(1'b1);
          end else if (ch == csvp_pkg::CH_COMMA) begin
            close_field();
          end else if (ch == csvp_pkg::CH_NEWLINE) begin
            close_record(1'b0);
          end else begin
            at_start = 1'b0;
            if (ch == csvp_pkg::CH_QUOTE) begin
              state = csvp_pkg::ST_QUOTED;
            end else begin
              state = csvp_pkg::ST_UNQUOTED;
              emit(csvp_pkg::K_CONTENT, ch, 8'h00, csvp_pkg::ERR_NONE, 1'b0);
            end
          end
        end
        csvp_pkg::ST_UNQUOTED: begin
          if (eoi) close_record(1'b1);
          else if (ch == csvp_pkg::CH_COMMA) close_field();
          else if (ch == csvp_pkg::CH_NEWLINE) close_record(1'b0);
          else if (ch == csvp_pkg::CH_QUOTE) abort(csvp_pkg::ERR_MISPLACED);
          else emit(csvp_pkg::K_CONTENT, ch, 8'h00, csvp_pkg::ERR_NONE, 1'b0);
        end
        csvp_pkg::ST_QUOTED: begin
          if (eoi) abort(csvp_pkg::ERR_NO_QUOTE);
          else if (ch == csvp_pkg::CH_QUOTE) state = csvp_pkg::ST_QUOTE_SEEN;
          else emit(csvp_pkg::K_CONTENT, ch, 8'h00, csvp_pkg::ERR_NONE, 1'b0);
        end
        csvp_pkg::ST_QUOTE_SEEN: begin
          if (eoi) begin
            close_record(1'b1);
          end else if (ch == csvp_pkg::CH_COMMA) begin
            close_field();
          end else if (ch == csvp_pkg::CH_NEWLINE) begin
            close_record(1'b0);
          end else if (ch == csvp_pkg::CH_QUOTE) begin
            state = csvp_pkg::ST_QUOTED;
            emit(csvp_pkg::K_CONTENT, ch, 8'h00, csvp_pkg::ERR_NONE, 1'b0);
          end else begin
            abort(csvp_pkg::ERR_ESCAPE);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("FAIL %s", msg);
      errors++;
    endtask

    task check_result(logic [31:0] data, logic [1:0] user);
      parse_res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result: kind %0d data %h", user, data));
        return;
      end
      want = expected_q.pop_front();
      if (user != want.kind)
        report($sformatf("kind: got %0d want %0d", user, want.kind));
      if (data[7:0] != want.ch)
        report($sformatf("char_out: got %h want %h", data[7:0], want.ch));
      if (data[15:8] != want.idx)
        report($sformatf("field_index: got %0d want %0d", data[15:8], want.idx));
      if (data[23:16] != want.recf)
        report($sformatf("record_fields: got %0d want %0d", data[23:16], want.recf));
      if (data[26:24] != want.err)
        report($sformatf("error_code: got %0d want %0d", data[26:24], want.err));
      if (data[27] != want.done)
        report($sformatf("done_res: got %0d want %0d", data[27], want.done));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic [0:0]  s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  csv_scoreboard sb;
  text_item_t    doc_q[$];
  bit            quiet = 1'b0;
  int unsigned   cycles = 0;

  csv_byte_stream_parser_core #(
    .MAX_FIELDS(MaxFields)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= !rst && (quiet || $urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tuser[0], s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void put_item(logic eoi, logic [7:0] ch);
    text_item_t t;
    t.eoi = eoi;
    t.ch  = ch;
    doc_q.insert(doc_q.size(), t);
  endfunction

  function automatic void put_byte(logic [7:0] ch);
    put_item(1'b0, ch);
  endfunction

  function automatic void put_eoi();
    put_item(1'b1, 8'($urandom));
  endfunction

  function automatic logic [7:0] plain_byte(bit in_quotes);
    logic [7:0] c;
    do begin
      c = $urandom_range(1) ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom);
    end while (c == csvp_pkg::CH_QUOTE ||
               (!in_quotes && (c == csvp_pkg::CH_COMMA || c == csvp_pkg::CH_NEWLINE)));
    return c;
  endfunction

  function automatic void put_field();
    int len;
    len = $urandom_range(6);
    case ($urandom_range(9))
      0, 1: ;
      2, 3, 4, 5: begin
        for (int i = 0; i <= len; i++) put_byte(plain_byte(1'b0));
      end
      default: begin
        put_byte(csvp_pkg::CH_QUOTE);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(7))
            0: begin
              put_byte(csvp_pkg::CH_QUOTE);
              put_byte(csvp_pkg::CH_QUOTE);
            end
            1: put_byte(csvp_pkg::CH_COMMA);
            2: put_byte(csvp_pkg::CH_NEWLINE);
            default: put_byte(plain_byte(1'b1));
          endcase
        end
        put_byte(csvp_pkg::CH_QUOTE);
      end
    endcase
  endfunction

  function automatic void put_record(int nf, bit ends);
    for (int f = 0; f < nf; f++) begin
      put_field();
      if (f < nf - 1) put_byte(csvp_pkg::CH_COMMA);
    end
    if (ends) put_byte(csvp_pkg::CH_NEWLINE);
  endfunction

  function automatic void build_doc();
    logic [7:0] opening [0:18];
    int         ending;
    int         k;
    int         n;
    opening = '{csvp_pkg::CH_QUOTE, csvp_pkg::CH_QUOTE, csvp_pkg::CH_COMMA, 8'h00,
                csvp_pkg::CH_COMMA, 8'hFF, csvp_pkg::CH_COMMA, csvp_pkg::CH_QUOTE,
                8'h78, csvp_pkg::CH_QUOTE, csvp_pkg::CH_QUOTE, csvp_pkg::CH_NEWLINE,
                csvp_pkg::CH_COMMA, csvp_pkg::CH_QUOTE, csvp_pkg::CH_NEWLINE,
                csvp_pkg::CH_COMMA, csvp_pkg::CH_COMMA, csvp_pkg::CH_COMMA,
                csvp_pkg::CH_NEWLINE};
    foreach (opening[i]) put_byte(opening[i]);
    ending = $urandom_range(7);
    while (doc_q.size() < ((ending == 3) ? 1000 : 1880)) put_record(NumFields, 1'b1);
    k = $urandom_range(NumFields - 1);
    case (ending)
      0: put_eoi();
      2: begin
        n = $urandom_range(1, 6);
        if (n >= NumFields) n++;
        put_record(n, $urandom_range(1));
        if (doc_q[doc_q.size() - 1].ch != csvp_pkg::CH_NEWLINE ||
            doc_q[doc_q.size() - 1].eoi)
          put_eoi();
      end
      3: put_record(FieldCap + $urandom_range(20), 1'b1);
      4, 5, 6: begin
        put_record(k, 1'b0);
        if (k > 0) put_byte(csvp_pkg::CH_COMMA);
        if (ending == 6) begin
          repeat ($urandom_range(1, 4)) put_byte(plain_byte(1'b0));
          put_byte(csvp_pkg::CH_QUOTE);
        end else begin
          put_byte(csvp_pkg::CH_QUOTE);
          repeat ($urandom_range(4)) put_byte(plain_byte(1'b1));
          if (ending == 4) begin
            put_byte(csvp_pkg::CH_QUOTE);
            put_byte(plain_byte(1'b0));
          end else begin
            put_eoi();
          end
        end
      end
      default: begin
        put_record(NumFields, 1'b0);
        put_eoi();
      end
    endcase
    repeat (8) put_item(1'($urandom_range(1)), 8'($urandom));
  endfunction

  task automatic send_doc();
    for (int i = 0; i < doc_q.size(); i++) begin
      quiet = (i >= 500 && i < 900);
      if (i == doc_q.size() / 2) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      while (!quiet && $urandom_range(99) < 16) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tuser  <= doc_q[i].eoi;
      s_tdata  <= doc_q[i].ch;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;
  endtask

  initial begin
    sb = new();
    build_doc();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_doc();
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
